@@ src/mdpvi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_pkg
// Shared kind codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package mdpvi_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_ENTRY  = 3'd0;
    localparam kind_t KIND_REWARD = 3'd1;
    localparam kind_t KIND_GROUP  = 3'd2;
    localparam kind_t KIND_VALUE  = 3'd3;
    localparam kind_t KIND_ACTION = 3'd4;
    localparam kind_t KIND_START  = 3'd5;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_NUM_STATES = 2'd0;
    localparam cfg_index_t REG_NUM_ROWS   = 2'd1;
    localparam cfg_index_t REG_EPSILON    = 2'd2;
    localparam cfg_index_t REG_MAX_ITER   = 2'd3;

endpackage

@@ src/mdp_value_iteration_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_value_iteration_top
// Max-reward value iteration over a sparse MDP held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): load items (matrix entries, rewards,
//   group starts, initial values and actions) are taken one per cycle and
//   written straight into synchronous memories. A start item launches a
//   solve; no further item is taken until every result has been delivered.
//   Solve: each sweep copies the rewards into the row sums, reads each
//   entry, multiplies it and adds it with a read-modify-write of its row
//   sum, then scans each group a row at a time. Sweeps repeat until the
//   largest rise is at or below epsilon_threshold or max_iterations is
//   reached.
//   Output channel (out_valid/out_stall): one item per state in order; a
//   stall holds the item. last marks the final state.
//   Configuration writes (cfg_valid/cfg_ready) are always accepted; write
//   only while idle.
//   Reset clears the entry count and control and sets the registers to
//   their defaults; memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
module mdp_value_iteration_top #(
    parameter int MAX_STATES  = 64,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mdpvi_pkg::kind_t              kind,
    input  logic [7:0]                    row,
    input  logic [5:0]                    column,
    input  logic [5:0]                    state,
    input  logic signed [31:0]            value,
    input  logic [7:0]                    action,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [5:0]                    out_state,
    output logic signed [31:0]            state_value,
    output logic [7:0]                    best_action,
    output logic [15:0]                   iterations_done,
    output logic                          limit_hit,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  mdpvi_pkg::cfg_index_t         cfg_index,
    input  logic [15:0]                   cfg_data
);
    import mdpvi_pkg::*;

    localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int VB = VALUE_BITS;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RCPY = 4'd1;
    localparam logic [3:0] ST_ERD  = 4'd2;
    localparam logic [3:0] ST_EMUL = 4'd3;
    localparam logic [3:0] ST_EACC = 4'd4;
    localparam logic [3:0] ST_GRD  = 4'd5;
    localparam logic [3:0] ST_GSET = 4'd6;
    localparam logic [3:0] ST_RRD  = 4'd7;
    localparam logic [3:0] ST_RCMP = 4'd8;
    localparam logic [3:0] ST_SEND = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;
    localparam logic [3:0] ST_ORD  = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;
    localparam logic [3:0] ST_RCW  = 4'd13;

    // memories
    logic signed [VB-1:0] ent_val_mem [MAX_ENTRIES];
    logic [7:0]           ent_row_mem [MAX_ENTRIES];
    logic [5:0]           ent_col_mem [MAX_ENTRIES];
    logic signed [VB-1:0] rew_mem     [MAX_ROWS];
    logic signed [VB-1:0] sum_mem     [MAX_ROWS];
    logic [7:0]           grp_mem     [MAX_STATES];
    logic signed [VB-1:0] val_mem     [MAX_STATES];
    logic [7:0]           act_mem     [MAX_STATES];

    logic [6:0]  num_states_reg;
    logic [8:0]  num_rows_reg;
    logic [15:0] eps_reg;
    logic [15:0] max_iter_reg;
    logic [EW:0] ent_cnt_reg;

    logic [3:0]  st_reg;
    logic [6:0]  ns_reg;
    logic [12:0] nr_reg;
    logic [15:0] cap_reg;
    logic [16:0] idx_reg;        // state counter
    logic        gph_reg;        // group read phase: own start, then next
    logic [12:0] r_reg;
    logic [12:0] end_reg;
    logic [7:0]  b_reg;
    logic [15:0] iters_reg;
    logic        limit_reg;
    logic [VB:0] rise_reg;
    logic signed [VB-1:0] best_reg;
    logic [7:0]  act_reg;
    logic        wrote_reg;      // previous row sum write, for forwarding
    logic [RW-1:0] wr_row_reg;
    logic signed [VB-1:0] wr_sum_reg;
    logic [EW:0] e_reg;

    // registered read data
    logic signed [VB-1:0] ev_q, rew_q, sum_q, val_q;
    logic [7:0]  er_q, grp_q, act_q;
    logic [5:0]  ec_q;
    logic signed [2*VB-1:0] prod_reg;
    logic        pvalid_reg;
    logic [7:0]  prow_reg;

    logic in_acc;
    assign in_stall  = (st_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    function automatic logic signed [VB-1:0] sat_add(
        input logic signed [VB-1:0] a, input logic signed [VB-1:0] b);
        logic signed [VB:0] s;
        s = {a[VB-1], a} + {b[VB-1], b};
        if (s[VB] != s[VB-1]) return s[VB] ? VMIN : VMAX;
        return s[VB-1:0];
    endfunction

    // product shifted by 16 (arithmetic shift floors), saturated
    logic signed [2*VB-1:0] pshift;
    logic signed [VB-1:0]   pq;
    always_comb
    begin
        pshift = prod_reg >>> 16;
        if (pshift > $signed({{VB{VMAX[VB-1]}}, VMAX})) pq = VMAX;
        else if (pshift < $signed({{VB{VMIN[VB-1]}}, VMIN})) pq = VMIN;
        else pq = pshift[VB-1:0];
    end

    logic [RW-1:0] in_row_a;
    logic [SW-1:0] in_st_a;
    assign in_row_a = RW'(row);
    assign in_st_a  = SW'(state);
    logic row_ok, st_ok;
    assign row_ok = ({5'd0, row} < 13'(MAX_ROWS));
    assign st_ok  = ({1'b0, state} < 7'(MAX_STATES));

    // addresses driven by control
    logic [SW-1:0] s_a, s1_a;
    logic [RW-1:0] r_a;
    logic [EW-1:0] e_a;
    assign s_a  = SW'(idx_reg);
    assign s1_a = SW'(idx_reg + 17'd1);
    assign r_a  = RW'(r_reg);
    assign e_a  = EW'(e_reg);

    // entry memories
    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_ENTRY && ent_cnt_reg < (EW+1)'(MAX_ENTRIES)) begin
            ent_val_mem[EW'(ent_cnt_reg)] <= value;
            ent_row_mem[EW'(ent_cnt_reg)] <= row;
            ent_col_mem[EW'(ent_cnt_reg)] <= column;
        end
        ev_q <= ent_val_mem[e_a];
        er_q <= ent_row_mem[e_a];
        ec_q <= ent_col_mem[e_a];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_REWARD && row_ok)
            rew_mem[in_row_a] <= value;
        rew_q <= rew_mem[r_a];
    end

    // row sums: one write port, one read port
    logic          sum_we;
    logic [RW-1:0] sum_wa;
    logic signed [VB-1:0] sum_wd;
    logic [RW-1:0] sum_ra;
    always_ff @(posedge clk)
    begin
        if (sum_we) sum_mem[sum_wa] <= sum_wd;
        sum_q <= sum_mem[sum_ra];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_GROUP && st_ok) grp_mem[in_st_a] <= row;
        grp_q <= grp_mem[(st_reg == ST_GRD && gph_reg) ? s1_a : s_a];
    end

    // values and actions
    logic val_we;
    logic [SW-1:0] val_wa;
    logic signed [VB-1:0] val_wd;
    logic [7:0] act_wd;
    logic [SW-1:0] val_ra;
    always_ff @(posedge clk)
    begin
        if (val_we) begin
            val_mem[val_wa] <= val_wd;
            act_mem[val_wa] <= act_wd;
        end else if (in_acc && kind == KIND_VALUE && st_ok) begin
            val_mem[in_st_a] <= value;
        end else if (in_acc && kind == KIND_ACTION && st_ok) begin
            act_mem[in_st_a] <= action;
        end
        val_q <= val_mem[val_ra];
        act_q <= act_mem[val_ra];
    end

    // products for entry accumulation
    always_ff @(posedge clk)
    begin
        prod_reg <= ev_q * val_q;
    end

    logic signed [VB-1:0] sum_fwd;
    assign sum_fwd = (wrote_reg && wr_row_reg == RW'(prow_reg)) ? wr_sum_reg : sum_q;

    // rise against the value held before this sweep
    logic [VB:0] diff;
    assign diff = {best_reg[VB-1], best_reg} - {val_q[VB-1], val_q};

    always_comb
    begin
        sum_we = 1'b0;
        sum_wa = r_a;
        sum_wd = rew_q;
        sum_ra = r_a;
        val_we = 1'b0;
        val_wa = s_a;
        val_wd = best_reg;
        act_wd = act_reg;
        val_ra = s_a;
        case (st_reg)
            ST_RCPY:
            begin
                sum_we = (r_reg != 13'd0);
                sum_wa = RW'(r_reg - 13'd1);
            end
            ST_ERD:
            begin
                val_ra = SW'(ec_q);
                sum_ra = RW'(er_q);
            end
            ST_EMUL:
            begin
                sum_ra = RW'(er_q);
            end
            ST_EACC:
            begin
                sum_we = pvalid_reg;
                sum_wa = RW'(prow_reg);
                sum_wd = sat_add(sum_fwd, pq);
            end
            ST_SEND:
            begin
                val_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            num_states_reg <= 7'd64;
            num_rows_reg   <= 9'd256;
            eps_reg        <= 16'd0;
            max_iter_reg   <= 16'd10000;
            ent_cnt_reg    <= '0;
            st_reg         <= ST_IDLE;
            out_valid      <= 1'b0;
            wrote_reg      <= 1'b0;
            pvalid_reg     <= 1'b0;
            gph_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_STATES: num_states_reg <= cfg_data[6:0];
                    REG_NUM_ROWS:   num_rows_reg   <= cfg_data[8:0];
                    REG_EPSILON:    eps_reg        <= cfg_data;
                    REG_MAX_ITER:   max_iter_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && kind == KIND_ENTRY && ent_cnt_reg < (EW+1)'(MAX_ENTRIES))
                ent_cnt_reg <= ent_cnt_reg + 1'b1;
            wrote_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (in_acc && kind == KIND_START) begin
                        ns_reg <= (num_states_reg == 7'd0) ? 7'd1 :
                                  (num_states_reg > 7'(MAX_STATES)) ? 7'(MAX_STATES)
                                                                   : num_states_reg;
                        nr_reg <= (num_rows_reg == 9'd0) ? 13'd1 :
                                  ({4'd0, num_rows_reg} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                                       : {4'd0, num_rows_reg};
                        cap_reg   <= (max_iter_reg == 16'd0) ? 16'd1 : max_iter_reg;
                        iters_reg <= '0;
                        r_reg     <= '0;
                        rise_reg  <= '0;
                        st_reg    <= ST_RCPY;
                    end
                end
                ST_RCPY:
                begin
                    // rew_q of row r-1 written this cycle
                    if (r_reg == nr_reg) begin
                        e_reg  <= '0;
                        st_reg <= ST_RCW;
                    end else begin
                        r_reg <= r_reg + 13'd1;
                    end
                end
                ST_RCW:
                begin
                    // entry read address set, data next cycle
                    st_reg <= (ent_cnt_reg == '0) ? ST_GRD : ST_ERD;
                    idx_reg <= '0;
                end
                ST_ERD:
                begin
                    // er_q/ec_q valid: read value and row sum
                    prow_reg   <= er_q;
                    pvalid_reg <= ({5'd0, er_q} < nr_reg) && ({1'b0, ec_q} < ns_reg);
                    st_reg     <= ST_EMUL;
                end
                ST_EMUL:
                begin
                    st_reg <= ST_EACC;
                end
                ST_EACC:
                begin
                    wrote_reg  <= pvalid_reg;
                    wr_row_reg <= RW'(prow_reg);
                    wr_sum_reg <= sat_add(sum_fwd, pq);
                    pvalid_reg <= 1'b0;
                    e_reg      <= e_reg + 1'b1;
                    if (e_reg + 1'b1 == ent_cnt_reg) begin
                        idx_reg <= '0;
                        st_reg  <= ST_GRD;
                    end else begin
                        st_reg <= ST_RCW;
                    end
                end
                ST_GRD:
                begin
                    // first phase reads this state's start, second the next one's
                    gph_reg <= ~gph_reg;
                    if (gph_reg) begin
                        b_reg   <= grp_q;
                        st_reg  <= ST_GSET;
                    end
                end
                ST_GSET:
                begin
                    if (idx_reg[6:0] + 7'd1 < ns_reg)
                        end_reg <= ({5'd0, grp_q} > nr_reg) ? nr_reg : {5'd0, grp_q};
                    else
                        end_reg <= nr_reg;
                    r_reg    <= {5'd0, b_reg};
                    best_reg <= val_q;
                    act_reg  <= act_q;
                    st_reg   <= ST_RRD;
                end
                ST_RRD:
                begin
                    if (r_reg >= end_reg) st_reg <= ST_SEND;
                    else st_reg <= ST_RCMP;
                end
                ST_RCMP:
                begin
                    if (sum_q > best_reg) begin
                        best_reg <= sum_q;
                        act_reg  <= 8'(r_reg - {5'd0, b_reg});
                    end
                    r_reg  <= r_reg + 13'd1;
                    st_reg <= ST_RRD;
                end
                ST_SEND:
                begin
                    // value written; val_q still holds the value before this sweep
                    if (!diff[VB] && diff > rise_reg) rise_reg <= diff;
                    if (idx_reg[6:0] + 7'd1 == ns_reg) begin
                        st_reg    <= ST_DONE;
                        iters_reg <= iters_reg + 16'd1;
                    end else begin
                        idx_reg <= {idx_reg[16:7], idx_reg[6:0] + 7'd1};
                        st_reg  <= ST_GRD;
                    end
                end
                ST_DONE:
                begin
                    idx_reg <= '0;
                    if (rise_reg <= {{(VB-15){1'b0}}, eps_reg}) begin
                        limit_reg <= 1'b0;
                        st_reg    <= ST_ORD;
                    end else if (iters_reg >= cap_reg) begin
                        limit_reg <= 1'b1;
                        st_reg    <= ST_ORD;
                    end else begin
                        r_reg    <= '0;
                        rise_reg <= '0;
                        st_reg   <= ST_RCPY;
                    end
                end
                ST_ORD:
                begin
                    st_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid) begin
                        out_valid       <= 1'b1;
                        out_state       <= 6'(idx_reg);
                        state_value     <= 32'(val_q);
                        best_action     <= act_q;
                        iterations_done <= iters_reg;
                        limit_hit       <= limit_reg;
                        last            <= (idx_reg[6:0] + 7'd1 == ns_reg);
                    end else if (!out_stall) begin
                        out_valid <= 1'b0;
                        if (last) begin
                            st_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 17'd1;
                            st_reg  <= ST_ORD;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/mdpvi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_props
// Port-level checks of the block's handshakes and result sequence.
// ----------------------------------------------------------------------------
module mdpvi_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  out_state,
    input logic        last,
    input logic [15:0] iterations_done
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_state))
        else $error("stalled item changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during output");

    a_iter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> iterations_done != 16'd0)
        else $error("result with no sweep");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid)
        else $error("item after last");
endmodule

bind mdp_value_iteration_top mdpvi_props u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .out_state(out_state), .last(last),
    .iterations_done(iterations_done)
);

@@ tb/sv/mdpvi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdpvi_checker
// Watches the load, configuration and result channels of the value
// iteration block. It keeps its own copy of the loaded MDP and registers,
// runs the sweeps itself on every start item and compares each delivered
// state result with the oldest one predicted.
// ----------------------------------------------------------------------------
module mdpvi_checker
    import mdpvi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  kind_t              kind,
    input  logic [7:0]         row,
    input  logic [5:0]         column,
    input  logic [5:0]         state,
    input  logic signed [31:0] value,
    input  logic [7:0]         action,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [5:0]         out_state,
    input  logic signed [31:0] state_value,
    input  logic [7:0]         best_action,
    input  logic [15:0]        iterations_done,
    input  logic               limit_hit,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct {
        logic [5:0]  st;
        logic [31:0] val;
        logic [7:0]  act;
        logic [15:0] iters;
        logic        lim;
        logic        fin;
    } state_result_t;

    state_result_t expected_states[$];

    longint ent_val[1024];
    int     ent_row[1024];
    int     ent_col[1024];
    int     n_entries;
    longint rewards[256];
    int     grp_first[64];
    longint vals[64];
    longint prev_vals[64];
    int     acts[64];
    longint sums[256];
    int     reg_states, reg_rows, reg_eps, reg_cap;
    int     fails;

    function automatic longint clamp(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // arithmetic shift floors, as the block rounds toward minus infinity
    function automatic longint q16_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp(p >>> 16);
    endfunction

    function automatic void run_value_iteration();
        int ns, nr, cap, iters, b, e, act;
        longint rise, best;
        logic lim;
        state_result_t res;
        ns = reg_states;
        nr = reg_rows;
        cap = reg_cap;
        if (ns < 1) ns = 1;
        if (ns > 64) ns = 64;
        if (nr < 1) nr = 1;
        if (nr > 256) nr = 256;
        if (cap < 1) cap = 1;
        iters = 0;
        lim = 1'b0;
        forever
        begin
            rise = 0;
            for (int r = 0; r < nr; r++) sums[r] = rewards[r];
            for (int k = 0; k < n_entries; k++)
                if (ent_row[k] < nr && ent_col[k] < ns)
                    sums[ent_row[k]] = clamp(sums[ent_row[k]]
                                             + q16_mul(ent_val[k], vals[ent_col[k]]));
            for (int s = 0; s < ns; s++) prev_vals[s] = vals[s];
            for (int s = 0; s < ns; s++)
            begin
                b = grp_first[s];
                e = (s + 1 < ns) ? grp_first[s + 1] : nr;
                if (e > nr) e = nr;
                best = vals[s];
                act = acts[s];
                for (int r = b; r < e; r++)
                    if (sums[r] > best)
                    begin
                        best = sums[r];
                        act = (r - b) & 8'hFF;
                    end
                vals[s] = best;
                acts[s] = act;
                if (best > prev_vals[s] && best - prev_vals[s] > rise)
                    rise = best - prev_vals[s];
            end
            iters++;
            if (rise <= reg_eps) break;
            if (iters >= cap)
            begin
                lim = 1'b1;
                break;
            end
        end
        for (int s = 0; s < ns; s++)
        begin
            res.st = s[5:0];
            res.val = vals[s][31:0];
            res.act = acts[s][7:0];
            res.iters = iters[15:0];
            res.lim = lim;
            res.fin = (s + 1 == ns);
            expected_states.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        state_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 1024; k++)
            begin
                ent_val[k] = 0;
                ent_row[k] = 0;
                ent_col[k] = 0;
            end
            for (int r = 0; r < 256; r++)
            begin
                rewards[r] = 0;
                sums[r] = 0;
            end
            for (int s = 0; s < 64; s++)
            begin
                grp_first[s] = 0;
                vals[s] = 0;
                prev_vals[s] = 0;
                acts[s] = 0;
            end
            n_entries = 0;
            reg_states = 64;
            reg_rows = 256;
            reg_eps = 0;
            reg_cap = 10000;
            fails = 0;
            expected_states.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_STATES: reg_states = cfg_data[6:0];
                    REG_NUM_ROWS:   reg_rows = cfg_data[8:0];
                    REG_EPSILON:    reg_eps = cfg_data;
                    REG_MAX_ITER:   reg_cap = cfg_data;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_ENTRY:
                        if (n_entries < 1024)
                        begin
                            ent_val[n_entries] = value;
                            ent_row[n_entries] = row;
                            ent_col[n_entries] = column;
                            n_entries++;
                        end
                    KIND_REWARD: rewards[row] = value;
                    KIND_GROUP:  grp_first[state] = row;
                    KIND_VALUE:  vals[state] = value;
                    KIND_ACTION: acts[state] = action;
                    KIND_START:  run_value_iteration();
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: unexpected result state %0d value %0d action %0d",
                             $time, out_state, state_value, best_action);
                    fails++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (out_state !== want.st || state_value !== want.val
                        || best_action !== want.act || iterations_done !== want.iters
                        || limit_hit !== want.lim || last !== want.fin)
                    begin
                        $display("%0t: result mismatch, expected state %0d value %0d",
                                 $time, want.st, $signed(want.val));
                        $display("    action %0d iters %0d limit %0d last %0d",
                                 want.act, want.iters, want.lim, want.fin);
                        $display("    actual state %0d value %0d action %0d",
                                 out_state, state_value, best_action);
                        $display("    iters %0d limit %0d last %0d",
                                 iterations_done, limit_hit, last);
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            pending <= expected_states.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the value iteration block: a short directed MDP, register
// extremes, random small MDPs with noise items, and a full-size run with
// oversized registers. The checker beside the block does the
// prediction; this module drives the channels and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
    import mdpvi_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    kind_t              kind;
    logic [7:0]         row;
    logic [5:0]         column;
    logic [5:0]         state;
    logic signed [31:0] value;
    logic [7:0]         action;
    logic               out_valid;
    logic               out_stall;
    logic [5:0]         out_state;
    logic signed [31:0] state_value;
    logic [7:0]         best_action;
    logic [15:0]        iterations_done;
    logic               limit_hit;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_index_t         cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    bit reward_set[256];
    bit group_set[64];
    bit value_set[64];
    bit action_set[64];
    int items_sent;
    int entries_sent;
    bit quiet;
    bit sender_idles;
    int stall_left;

    mdp_value_iteration_top DUT (.*);
    mdpvi_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #40ms;
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure in bursts
    always @(posedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left--;
        else
        begin
            out_stall <= 1'($urandom_range(0, 1));
            stall_left = $urandom_range(1, 12);
        end
    end

    function automatic logic [31:0] small_q16();
        return $urandom_range(0, 32'h80000) - 32'h40000;
    endfunction

    task automatic send_item(input kind_t k, input logic [7:0] r, input logic [5:0] c,
                             input logic [5:0] s, input logic [31:0] v,
                             input logic [7:0] a);
        if (!quiet && sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        row <= r;
        column <= c;
        state <= s;
        value <= v;
        action <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (k)
            KIND_ENTRY:  entries_sent++;
            KIND_REWARD: reward_set[r] = 1'b1;
            KIND_GROUP:  group_set[s] = 1'b1;
            KIND_VALUE:  value_set[s] = 1'b1;
            KIND_ACTION: action_set[s] = 1'b1;
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic wait_drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // start, then hold off until every state result is back
    task automatic solve_and_drain();
        send_item(KIND_START, 8'd0, 6'd0, 6'd0, 32'd0, 8'd0);
        in_valid <= 1'b0;
        wait_drain();
    endtask

    task automatic set_regs(input int ns, input int nr, input int eps, input int cap);
        cfg_index_t idx[4];
        int data[4];
        idx = '{REG_NUM_STATES, REG_NUM_ROWS, REG_EPSILON, REG_MAX_ITER};
        data = '{ns, nr, eps, cap};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= 16'(data[i]);
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // write whatever a solve over ns states and nr rows would read unwritten
    task automatic fill_missing(input int ns, input int nr);
        for (int r = 0; r < nr; r++)
            if (!reward_set[r])
                send_item(KIND_REWARD, 8'(r), 6'd0, 6'd0, small_q16(), 8'd0);
        for (int s = 0; s < ns; s++)
        begin
            if (!group_set[s])
                send_item(KIND_GROUP, 8'((s * nr) / ns), 6'd0, 6'(s), 32'd0, 8'd0);
            if (!value_set[s])
                send_item(KIND_VALUE, 8'd0, 6'd0, 6'(s), small_q16(), 8'd0);
            if (!action_set[s])
                send_item(KIND_ACTION, 8'd0, 6'd0, 6'(s), 32'd0,
                          8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_mdp();
        int ns, nr, eps, cap, n;
        kind_t k;
        logic [31:0] v;
        ns = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        nr = $urandom_range(1, 3 * ns + 1);
        case ($urandom_range(0, 3))
            0: eps = 0;
            1: eps = 65535;
            2: eps = $urandom_range(0, 65535);
            default: eps = $urandom_range(0, 256);
        endcase
        cap = $urandom_range(1, 6);
        set_regs(ns, nr, eps, cap);
        sender_idles = 1'($urandom_range(0, 1));
        for (int s = 0; s < ns; s++)
        begin
            if ($urandom_range(0, 3) != 0)
                send_item(KIND_GROUP, 8'((s * nr) / ns + $urandom_range(0, 1)), 6'd0,
                          6'(s), 32'd0, 8'd0);
            if ($urandom_range(0, 1) == 0)
            begin
                v = ($urandom_range(0, 7) == 0) ? $urandom() : small_q16();
                send_item(KIND_VALUE, 8'd0, 6'd0, 6'(s), v, 8'd0);
            end
            if ($urandom_range(0, 1) == 0)
                send_item(KIND_ACTION, 8'd0, 6'd0, 6'(s), 32'd0,
                          8'($urandom_range(0, 255)));
        end
        for (int r = 0; r < nr; r++)
            if ($urandom_range(0, 2) != 0)
            begin
                v = ($urandom_range(0, 7) == 0) ? $urandom() : small_q16();
                send_item(KIND_REWARD, 8'(r), 6'd0, 6'd0, v, 8'd0);
            end
        n = $urandom_range(0, nr + ns);
        for (int i = 0; i < n; i++)
            send_item(KIND_ENTRY,
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, nr - 1)),
                      6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, ns - 1)),
                      6'd0,
                      ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 16'h3000),
                      8'd0);
        // noise: any kind but start, all fields random
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            k = kind_t'($urandom_range(0, 6));
            if (k >= KIND_START) k = k + 3'd1;
            send_item(k, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), $urandom(), 8'($urandom_range(0, 255)));
        end
        fill_missing(ns, nr);
        solve_and_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_ENTRY;
        row = '0;
        column = '0;
        state = '0;
        value = '0;
        action = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_NUM_STATES;
        cfg_data = '0;
        quiet = 1'b0;
        sender_idles = 1'b1;
        stall_left = 0;
        items_sent = 0;
        entries_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: two states over four rows, saturating rewards and products,
        // a tie, skipped entries and unknown kinds
        set_regs(2, 4, 0, 3);
        send_item(KIND_REWARD, 8'd0, 6'd0, 6'd0, 32'h7FFFFFFF, 8'd0);
        send_item(KIND_REWARD, 8'd1, 6'd0, 6'd0, 32'h80000000, 8'd0);
        send_item(KIND_REWARD, 8'd2, 6'd0, 6'd0, 32'h00010000, 8'd0);
        send_item(KIND_REWARD, 8'd3, 6'd0, 6'd0, 32'h00000000, 8'd0);
        send_item(KIND_GROUP, 8'd0, 6'd0, 6'd0, 32'd0, 8'd0);
        send_item(KIND_GROUP, 8'd2, 6'd0, 6'd1, 32'd0, 8'd0);
        send_item(KIND_VALUE, 8'd0, 6'd0, 6'd0, 32'h80000000, 8'd0);
        send_item(KIND_VALUE, 8'd0, 6'd0, 6'd1, 32'h00010000, 8'd0);
        send_item(KIND_ACTION, 8'd0, 6'd0, 6'd0, 32'd0, 8'hFF);
        send_item(KIND_ACTION, 8'd0, 6'd0, 6'd1, 32'd0, 8'h00);
        send_item(KIND_ENTRY, 8'd1, 6'd1, 6'd0, 32'h7FFFFFFF, 8'd0);
        send_item(KIND_ENTRY, 8'd3, 6'd0, 6'd0, 32'h80000000, 8'd0);
        send_item(KIND_ENTRY, 8'd3, 6'd1, 6'd0, 32'hFFFF8000, 8'd0);
        send_item(KIND_ENTRY, 8'd255, 6'd63, 6'd63, 32'h00008000, 8'd0);
        send_item(3'd6, 8'hFF, 6'h3F, 6'h3F, 32'hFFFFFFFF, 8'hFF);
        send_item(3'd7, 8'h00, 6'h00, 6'h00, 32'h00000000, 8'h00);
        solve_and_drain();
        // a second start carries on from the values left behind
        solve_and_drain();
        // zero registers act as one state, one row, one sweep
        set_regs(0, 0, 0, 0);
        solve_and_drain();

        while (items_sent < 100) random_mdp();

        // longest cap, but no row can beat the saturated values
        set_regs(4, 8, 65535, 65535);
        fill_missing(4, 8);
        for (int r = 0; r < 8; r++)
            send_item(KIND_REWARD, 8'(r), 6'd0, 6'd0, 32'h80000000, 8'd0);
        for (int s = 0; s < 4; s++)
            send_item(KIND_VALUE, 8'd0, 6'd0, 6'(s), 32'h7FFFFFFF, 8'd0);
        solve_and_drain();

        // full size with oversized registers
        quiet = 1'b1;
        set_regs(127, 511, int'($urandom_range(0, 65535)), 2);
        fill_missing(64, 256);
        repeat (16)
            send_item(KIND_ENTRY, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      6'd0, $urandom_range(0, 16'h1000), 8'd0);
        solve_and_drain();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
